// File: hdl/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: hdl/hmde_pkg.sv
// Package: widths, codes and shared types of the haptic duty envelope block.
`default_nettype none

package hmde_pkg;

   localparam int OP_W   = 3;
   localparam int TIME_W = 32;
   localparam int DUTY_W = 8;
   localparam int DUR_W  = 16;
   localparam int RAMP_W = DUR_W - 2;          // quarter of the envelope length
   localparam int PROD_W = DUR_W + DUTY_W;     // ramp position times peak duty
   localparam int DIV_CNT_W = $clog2(DUTY_W);

   localparam logic [DUTY_W-1:0] PEAK_DUTY_DEF = 8'd170;

   // opcodes
   localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_WANTED  = 3'd1;
   localparam logic [OP_W-1:0] OP_PULSE       = 3'd2;
   localparam logic [OP_W-1:0] OP_CALM_START  = 3'd3;
   localparam logic [OP_W-1:0] OP_CALM_CANCEL = 3'd4;
   localparam logic [OP_W-1:0] OP_CANCEL_ALL  = 3'd5;

   // intensity levels
   localparam logic [1:0] INT_HALF    = 2'd1;
   localparam logic [1:0] INT_THREE_Q = 2'd2;
   localparam logic [1:0] INT_FULL    = 2'd3;

   // register file
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_BIT = 2;
   localparam logic REG_THERAPY_MODE = 1'b0;
   localparam logic REG_INTENSITY    = 1'b1;

   typedef struct packed {
      logic       therapy_mode;
      logic [1:0] intensity_level;
   } csr_cfg_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [RAMP_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DUTY_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: hdl/hmde_channels.sv
// Interfaces: command item channel and result item channel.
`default_nettype none

interface hmde_req_if
   import hmde_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [TIME_W-1:0] now_ms;
   logic [DUTY_W-1:0] duty_in;
   logic [DUR_W-1:0]  duration_ms;
   logic              therapy_running;
   logic              calibration_running;
   logic              training_alert;

   modport source (
      output valid, opcode, now_ms, duty_in, duration_ms,
             therapy_running, calibration_running, training_alert,
      input  ready
   );
   modport sink (
      input  valid, opcode, now_ms, duty_in, duration_ms,
             therapy_running, calibration_running, training_alert,
      output ready
   );
endinterface

interface hmde_rsp_if
   import hmde_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] applied_duty;
   logic              motor_busy;
   logic              output_on;

   modport source (
      output valid, applied_duty, motor_busy, output_on,
      input  ready
   );
   modport sink (
      input  valid, applied_duty, motor_busy, output_on,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/hmde_csr.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module hmde_csr
   import hmde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output csr_cfg_type           cfg
);

   logic       mode_ff, mode_in;
   logic [1:0] level_ff, level_in;
   logic       wr_en;
   logic       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_IDX_BIT];

   always_comb begin
      mode_in  = mode_ff;
      level_in = level_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_THERAPY_MODE: mode_in  = pwdata[0];
            REG_INTENSITY:    level_in = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_THERAPY_MODE: prdata = {31'd0, mode_ff};
         REG_INTENSITY:    prdata = {30'd0, level_ff};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         level_ff <= INT_THREE_Q;
      end else begin
         mode_ff  <= mode_in;
         level_ff <= level_in;
      end
   end

   assign cfg.therapy_mode    = mode_ff;
   assign cfg.intensity_level = level_ff;

endmodule

`default_nettype wire

// File: hdl/hmde_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope ramp level.
`default_nettype none

module hmde_div
   import hmde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    den_ff, den_in;
   logic [DUTY_W-1:0]    quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 fits;

   // quotient is known to stay below 2^DUTY_W, so the divisor starts shifted
   // up by DUTY_W-1 and walks down one place a step
   assign fits = rem_ff >= den_ff;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = div_req.dividend;
         den_in = PROD_W'({div_req.divisor, {(DUTY_W-1){1'b0}}});
         quo_in = '0;
         cnt_in = DIV_CNT_W'(DUTY_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         quo_in = {quo_ff[DUTY_W-2:0], fits};
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// File: hdl/haptic_motor_duty_envelope_core.sv
// Top level: vibration motor duty selection with pulse, calm envelope and scaling.
// Usage
//   req_chan carries one command or tick item (opcode, now_ms, duty_in,
//   duration_ms and three external busy flags); rsp_chan returns exactly one
//   result item per request item: applied_duty, motor_busy and output_on.
//   Both channels move an item on a clock edge with valid and ready high.
//   The APB-style port (psel/penable/pwrite/paddr/pwdata) sets therapy_mode
//   at byte 0 and intensity_level at byte 4; pready is tied high and writes
//   land on the access cycle. Write it only while the block is idle.
// Timing
//   One item in flight at a time; req_chan.ready is high only in idle.
//   Most items pass decode (ST_EVAL), then result load (ST_FIN). A tick on an
//   envelope ramp adds a multiply state (ST_MUL) and the 8-step divider
//   (ST_DIV) between the two.
// Stall
//   The result sits in an output register. A new item is accepted while it
//   waits; that item's result is held back until the old one is taken.
// Reset
//   Synchronous, active high: all duty/timer state cleared, no pulse and no
//   envelope, therapy_mode 0, intensity_level three quarters.
`default_nettype none
`include "assert_macros.svh"

module haptic_motor_duty_envelope_core
   import hmde_pkg::*;
#(
   parameter logic [DUTY_W-1:0] PEAK_DUTY = PEAK_DUTY_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   hmde_req_if.sink              req_chan,
   hmde_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EVAL = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   csr_cfg_type cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type state_ff, state_in;

   // captured item
   logic [OP_W-1:0]   op_ff, op_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              ext_ff, ext_in;

   // motor state
   logic [DUTY_W-1:0] wanted_ff, wanted_in;
   logic [DUTY_W-1:0] cur_ff, cur_in;
   logic [DUTY_W-1:0] pulse_duty_ff, pulse_duty_in;
   logic [TIME_W-1:0] pulse_end_ff, pulse_end_in;
   logic [TIME_W-1:0] calm_start_ff, calm_start_in;
   logic [DUR_W-1:0]  calm_len_ff, calm_len_in;
   logic              busy_flag_ff, busy_flag_in;

   // ramp level path
   logic [DUR_W-1:0]  num_ff, num_in;
   logic [RAMP_W-1:0] ramp_ff, ramp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              div_start_ff, div_start_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic              rsp_on_ff, rsp_on_in;

   logic              req_fire;
   logic [TIME_W-1:0] pulse_diff;
   logic [TIME_W-1:0] calm_elapsed;
   logic [DUR_W-1:0]  elapsed;
   logic [RAMP_W-1:0] ramp;
   logic [DUR_W-1:0]  hold_end;
   logic              pulse_pend;
   logic              calm_pend;
   logic              apply_en;
   logic [DUTY_W-1:0] apply_val;
   logic [DUTY_W-1:0] scaled;
   logic              rsp_load;

   function automatic logic [DUTY_W-1:0] scale_duty(input logic [DUTY_W-1:0] d,
                                                    input csr_cfg_type c);
      logic [DUTY_W+1:0] x3;
      logic [DUTY_W-1:0] r;
      begin
         x3 = {2'b00, d} + {1'b0, d, 1'b0};
         r  = d;
         if (c.therapy_mode) begin
            if (c.intensity_level == INT_HALF) begin
               r = d >> 1;
            end else if (c.intensity_level != INT_FULL) begin
               r = x3[DUTY_W+1:2];
            end
         end
         return r;
      end
   endfunction

   hmde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = prod_ff;
   assign div_req.divisor  = ramp_ff;

   hmde_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   // timer checks, always against the stored state (updated state in ST_FIN)
   assign pulse_diff   = now_ff - pulse_end_ff;
   assign calm_elapsed = now_ff - calm_start_ff;
   assign pulse_pend   = (pulse_end_ff != '0) && pulse_diff[TIME_W-1];
   assign calm_pend    = (calm_len_ff != '0) && (calm_elapsed < TIME_W'(calm_len_ff));

   // envelope shape; elapsed fits DUR_W whenever the envelope is live
   assign elapsed  = calm_elapsed[DUR_W-1:0];
   assign ramp     = calm_len_ff[DUR_W-1:2];
   assign hold_end = calm_len_ff - DUR_W'(ramp);

   assign scaled   = scale_duty(apply_val, cfg);
   assign rsp_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      duty_in       = duty_ff;
      dur_in        = dur_ff;
      ext_in        = ext_ff;
      wanted_in     = wanted_ff;
      pulse_duty_in = pulse_duty_ff;
      pulse_end_in  = pulse_end_ff;
      calm_start_in = calm_start_ff;
      calm_len_in   = calm_len_ff;
      num_in        = num_ff;
      ramp_in       = ramp_ff;
      prod_in       = prod_ff;
      div_start_in  = 1'b0;
      apply_en      = 1'b0;
      apply_val     = wanted_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.opcode;
               now_in   = req_chan.now_ms;
               duty_in  = req_chan.duty_in;
               dur_in   = req_chan.duration_ms;
               ext_in   = req_chan.therapy_running | req_chan.calibration_running |
                          req_chan.training_alert;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            state_in = ST_FIN;
            case (op_ff)
               OP_TICK: begin
                  if (pulse_end_ff != '0 && !pulse_pend) begin
                     pulse_end_in = '0;
                  end
                  if (pulse_pend) begin
                     apply_en  = 1'b1;
                     apply_val = pulse_duty_ff;
                  end else if (calm_pend) begin
                     ramp_in = ramp;
                     if (ramp == '0) begin
                        // envelope too short to ramp: flat at peak
                        apply_en  = 1'b1;
                        apply_val = PEAK_DUTY;
                     end else if (elapsed < DUR_W'(ramp)) begin
                        num_in   = elapsed;
                        state_in = ST_MUL;
                     end else if (elapsed < hold_end) begin
                        apply_en  = 1'b1;
                        apply_val = PEAK_DUTY;
                     end else begin
                        num_in   = calm_len_ff - elapsed;
                        state_in = ST_MUL;
                     end
                  end else begin
                     calm_len_in = '0;
                     apply_en    = 1'b1;
                     apply_val   = wanted_ff;
                  end
               end
               OP_SET_WANTED: begin
                  wanted_in = duty_ff;
                  if (pulse_end_ff != '0 && !pulse_pend) begin
                     pulse_end_in = '0;
                  end
                  // a live pulse keeps the motor at its duty
                  if (!pulse_pend) begin
                     apply_en  = 1'b1;
                     apply_val = duty_ff;
                  end
               end
               OP_PULSE: begin
                  if (dur_ff != '0) begin
                     pulse_duty_in = duty_ff;
                     pulse_end_in  = now_ff + TIME_W'(dur_ff);
                     calm_len_in   = '0;
                     apply_en      = 1'b1;
                     apply_val     = duty_ff;
                  end
               end
               OP_CALM_START: begin
                  if (dur_ff != '0) begin
                     pulse_end_in  = '0;
                     calm_start_in = now_ff;
                     calm_len_in   = dur_ff;
                     apply_en      = 1'b1;
                     apply_val     = '0;
                  end
               end
               OP_CALM_CANCEL: begin
                  if (calm_len_ff != '0) begin
                     calm_len_in = '0;
                     apply_en    = 1'b1;
                     apply_val   = wanted_ff;
                  end
               end
               OP_CANCEL_ALL: begin
                  pulse_end_in  = '0;
                  pulse_duty_in = '0;
                  calm_len_in   = '0;
                  apply_en      = 1'b1;
                  apply_val     = wanted_ff;
               end
               default: ;
            endcase
         end

         ST_MUL: begin
            prod_in      = PROD_W'(num_ff) * PROD_W'(PEAK_DUTY);
            div_start_in = 1'b1;
            state_in     = ST_DIV;
         end

         ST_DIV: begin
            if (div_rsp.done) begin
               apply_en  = 1'b1;
               apply_val = (div_rsp.quotient > PEAK_DUTY) ? PEAK_DUTY : div_rsp.quotient;
               state_in  = ST_FIN;
            end
         end

         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign cur_in       = apply_en ? scaled : cur_ff;
   assign busy_flag_in = apply_en ? (scaled != '0) : busy_flag_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_busy_in  = rsp_busy_ff;
      rsp_on_in    = rsp_on_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_duty_in  = cur_ff;
         rsp_busy_in  = busy_flag_ff | pulse_pend | calm_pend | ext_ff;
         rsp_on_in    = (cur_ff != '0);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_start_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         wanted_ff     <= '0;
         cur_ff        <= '0;
         pulse_duty_ff <= '0;
         pulse_end_ff  <= '0;
         calm_start_ff <= '0;
         calm_len_ff   <= '0;
         busy_flag_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_start_ff  <= div_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         wanted_ff     <= wanted_in;
         cur_ff        <= cur_in;
         pulse_duty_ff <= pulse_duty_in;
         pulse_end_ff  <= pulse_end_in;
         calm_start_ff <= calm_start_in;
         calm_len_ff   <= calm_len_in;
         busy_flag_ff  <= busy_flag_in;
      end
      op_ff       <= op_in;
      now_ff      <= now_in;
      duty_ff     <= duty_in;
      dur_ff      <= dur_in;
      ext_ff      <= ext_in;
      num_ff      <= num_in;
      ramp_ff     <= ramp_in;
      prod_ff     <= prod_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_on_ff   <= rsp_on_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.applied_duty = rsp_duty_ff;
   assign rsp_chan.motor_busy   = rsp_busy_ff;
   assign rsp_chan.output_on    = rsp_on_ff;

   // a nonzero duty always reports busy
   `ASSERT_PROP(a_on_implies_busy, clock, reset,
                rsp_chan.valid && rsp_chan.output_on |-> rsp_chan.motor_busy,
                "motor on but not reported busy")

   // one item at a time: after an accept, ready drops
   `ASSERT_PROP(a_single_item, clock, reset,
                req_fire |=> !req_chan.ready,
                "item accepted while another is in flight")

   // divider finishes only while the sequencer waits for it
   `ASSERT_PROP(a_div_done_in_div, clock, reset,
                div_rsp.done |-> (state_ff == ST_DIV),
                "divider result outside the divide phase")

   `ASSERT_PROP(a_state_onehot, clock, reset,
                $onehot(state_ff),
                "sequencer state not one-hot")

endmodule

`default_nettype wire
